[rtl/core/swm_pkg.sv]
package swm_pkg;

    localparam int DATA_W = 32;
    localparam int WS_W   = 7;
    localparam int ADDR_W = 3;
    localparam int APB_W  = 32;

    localparam logic [WS_W-1:0] WS_RESET = 7'd3;

    // register index taken from paddr[2]
    localparam logic REG_WINDOW_SIZE = 1'b0;

    typedef struct packed {
        logic                     alive;
        logic signed [DATA_W-1:0] value;
    } t_link;

endpackage

[rtl/core/sliding_window_max.sv]
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_ready    i_sample, i_start_req
// output    out        o_out_valid / i_out_ready  o_window_max
// config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// one transaction per cycle unless the output stalls; o_out_valid registers from r_pend
// the cycle time is set by the oldest-live-cell select over all WINDOW_MAX cells
// reset clears the cell live bits, the fill count and the output valid; window_size is 3
// a stalled output holds one more finished transaction, then o_in_ready drops
module sliding_window_max import swm_pkg::*; #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [DATA_W-1:0] i_sample,
    input  logic                     i_start_req,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_window_max,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic        [ADDR_W-1:0] paddr,
    input  logic        [APB_W-1:0]  pwdata,
    output logic        [APB_W-1:0]  prdata,
    output logic                     pready
);

    localparam int AW = $clog2(WINDOW_MAX + 1);
    localparam int CW = (AW > WS_W) ? AW : WS_W;

    logic [WS_W-1:0]          r_window_size;
    logic [AW-1:0]            r_fill;
    logic [AW-1:0]            n_fill;
    logic                     r_pend;
    logic                     r_pend_emit;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_data;
    logic [CW-1:0]            w_eff;
    logic                     in_acc;
    logic                     out_free;
    logic                     emit;
    logic                     cfg_wr;
    logic signed [DATA_W-1:0] front;
    t_link                    head_link;
    t_link [WINDOW_MAX-1:0]   cells;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WS_RESET;
        end else if (cfg_wr && paddr[2] == REG_WINDOW_SIZE) begin
            r_window_size <= pwdata[WS_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? APB_W'(r_window_size) : '0;

    always_comb begin
        if (r_window_size == '0) begin
            w_eff = CW'(1);
        end else if (CW'(r_window_size) > CW'(WINDOW_MAX)) begin
            w_eff = CW'(WINDOW_MAX);
        end else begin
            w_eff = CW'(r_window_size);
        end
    end

    // handshake
    assign out_free   = ~r_out_valid | i_out_ready;
    assign o_in_ready = ~r_pend | out_free;
    assign in_acc     = i_in_valid & o_in_ready;

    always_comb begin
        if (i_start_req) begin
            n_fill = AW'(1);
        end else if (r_fill == AW'(WINDOW_MAX)) begin
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + AW'(1);
        end
    end

    assign emit = (CW'(n_fill) >= w_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_pend_emit <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_fill      <= n_fill;
                r_pend      <= 1'b1;
                r_pend_emit <= emit;
            end else if (out_free) begin
                r_pend <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_pend & r_pend_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_pend && r_pend_emit) begin
            r_out_data <= front;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_window_max = r_out_data;

    // cell chain, youngest at index 0
    assign head_link.alive = 1'b1;
    assign head_link.value = i_sample;

    for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
        swm_cell #(
            .POS (j),
            .CW  (CW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (in_acc),
            .i_start  (i_start_req),
            .i_sample (i_sample),
            .i_win    (w_eff),
            .i_prev   ((j == 0) ? head_link : cells[(j == 0) ? 0 : j-1]),
            .o_cell   (cells[j])
        );
    end

    swm_front_sel #(
        .N (WINDOW_MAX)
    ) u_front_sel (
        .i_cells (cells),
        .o_front (front)
    );

endmodule

[rtl/core/swm_cell.sv]
module swm_cell import swm_pkg::*; #(
    parameter int POS = 0,
    parameter int CW  = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_start,
    input  logic signed [DATA_W-1:0] i_sample,
    input  logic        [CW-1:0]     i_win,
    input  t_link                    i_prev,
    output t_link                    o_cell
);

    localparam bit HEAD = (POS == 0);

    logic                     r_alive;
    logic                     n_alive;
    logic signed [DATA_W-1:0] r_value;

    // the cell at position POS holds the sample of age POS
    always_comb begin
        if (HEAD) begin
            n_alive = 1'b1;
        end else begin
            n_alive = i_prev.alive & ~i_start & (i_prev.value > i_sample)
                      & (CW'(POS) < i_win);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= 1'b0;
        end else if (i_en) begin
            r_alive <= n_alive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= i_prev.value;
        end
    end

    assign o_cell.alive = r_alive;
    assign o_cell.value = r_value;

endmodule

[rtl/core/swm_front_sel.sv]
module swm_front_sel import swm_pkg::*; #(
    parameter int N = 64
) (
    input  t_link [N-1:0]            i_cells,
    output logic signed [DATA_W-1:0] o_front
);

    localparam int P = 2 ** $clog2(N);

    t_link node [2*P-1];

    // oldest live cell wins: higher index is older
    for (genvar j = 0; j < P; j++) begin : g_leaf
        if (j < N) begin : g_used
            assign node[P-1+j] = i_cells[j];
        end else begin : g_pad
            assign node[P-1+j] = '0;
        end
    end

    for (genvar i = 0; i < P-1; i++) begin : g_node
        assign node[i] = node[2*i+2].alive ? node[2*i+2] : node[2*i+1];
    end

    assign o_front = node[0].value;

endmodule

[rtl/core/swm_checker.sv]
module swm_checker import swm_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic signed [DATA_W-1:0] o_window_max
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_window_max))
        else $error("output payload changed while stalled");

    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input blocked without a stalled output");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind sliding_window_max swm_checker u_swm_checker (.*);
